// ===== hw/rtl/upi_pkg.sv =====
// ----------------------------------------------------------------------------
// upi_pkg
// Shared types and fixed-point constants for the unicycle pose integrator.
// ----------------------------------------------------------------------------
package upi_pkg;

  // angles in Q28 radians, CORDIC vectors in Q30
  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;

  // atan(2^-i) in Q28, the last two entries round to zero
  localparam logic signed [31:0] ATAN_Q28 [0:31] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32,
    32'sd16,        32'sd8,         32'sd4,        32'sd2,
    32'sd1,         32'sd1,         32'sd0,        32'sd0
  };

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LENGTH = 8'd1;

  localparam logic [15:0] TIME_STEP_RST = 16'd1966;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] turn_rate;
  } upi_cmd_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               saturated;
  } upi_pose_t;

  typedef struct packed {
    logic signed [31:0] cos_val;
    logic signed [31:0] sin_val;
  } upi_trig_t;

endpackage

// ===== hw/rtl/unicycle_pose_integrator_top.sv =====
// ----------------------------------------------------------------------------
// unicycle_pose_integrator_top
// Unicycle odometry: CORDIC velocity split, trapezoid integration of
// position and heading, heading wrap, position clamp, offset point.
// ----------------------------------------------------------------------------
//  channel  signals                           width   direction
//  cmd      cmd_valid cmd_ready cmd_data      32      request in
//  pose     pose_valid pose_ready pose_data   145     request out
//  cfg      cfg_valid cfg_ready cfg_index     8 + 16  register write in
//           cfg_data
//
//  A request passes twice through the single CORDIC unit, makes 7 passes of
//  the shared 33x17 multiplier and runs the heading wrap states before its
//  pose is registered.
//  cmd_ready is high only while the sequencer is idle.
//  A finished pose waits in the output register while pose_ready is low.
//  Synchronous reset clears pose, rates, offset_length; time_step gets 1966.
// ----------------------------------------------------------------------------
module unicycle_pose_integrator_top
  import upi_pkg::*;
#(
  parameter int CORDIC_STEPS  = 16,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  upi_cmd_t             cmd_data,
  output logic                 pose_valid,
  input  logic                 pose_ready,
  output upi_pose_t            pose_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int RATE_SH = 18;
  localparam int POS_SH  = 41 - POS_FRAC_BITS;
  localparam int PT_SH   = 42 - POS_FRAC_BITS;
  localparam logic signed [50:0] RATE_HALF = 51'sd1 <<< (RATE_SH - 1);
  localparam logic signed [50:0] POS_HALF  = 51'sd1 <<< (POS_SH - 1);
  localparam logic signed [50:0] PT_HALF   = 51'sd1 <<< (PT_SH - 1);
  localparam logic signed [33:0] PI34      = 34'sd843314857;
  localparam logic signed [33:0] TWO_PI34  = 34'sd1686629714;

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT1, S_MXR, S_MYR, S_MDX, S_MDY, S_MDH, S_WRAP0,
    S_WRAP, S_WAIT2, S_MPX, S_MPY, S_PYF, S_OUT
  } state_t;

  state_t             state;
  logic [15:0]        time_step;
  logic [15:0]        offset_length;
  logic signed [15:0] spd;
  logic signed [15:0] trn;
  logic signed [31:0] x_acc;
  logic signed [31:0] y_acc;
  logic signed [31:0] heading_acc;
  logic signed [31:0] last_x_rate;
  logic signed [31:0] last_y_rate;
  logic signed [15:0] last_turn_rate;
  logic signed [31:0] xr;
  logic signed [31:0] yr;
  logic signed [31:0] cs;
  logic signed [31:0] sn;
  logic signed [33:0] t;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic               sat;

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [50:0] mul_ext;
  logic signed [50:0] rate_r;
  logic signed [50:0] pos_r;
  logic signed [50:0] pt_r;
  logic signed [50:0] hd_r;
  logic signed [33:0] step_d;
  logic signed [31:0] base;
  logic signed [33:0] acc_sum;
  logic               acc_ovf;
  logic signed [31:0] acc_clamped;
  logic signed [33:0] head_wide;
  logic signed [31:0] head_new;
  logic               wrap_done;

  logic               cor_start;
  logic signed [31:0] cor_angle;
  logic               cor_done;
  upi_trig_t          cor_trig;

  assign cmd_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    case (state)
      S_MXR: begin
        mul_a = 33'(cs);
        mul_b = 17'(spd);
      end
      S_MYR: begin
        mul_a = 33'(sn);
        mul_b = 17'(spd);
      end
      S_MDX: begin
        mul_a = 33'(xr) + 33'(last_x_rate);
        mul_b = signed'({1'b0, time_step});
      end
      S_MDY: begin
        mul_a = 33'(yr) + 33'(last_y_rate);
        mul_b = signed'({1'b0, time_step});
      end
      S_MDH: begin
        mul_a = 33'(trn) + 33'(last_turn_rate);
        mul_b = signed'({1'b0, time_step});
      end
      S_MPX: begin
        mul_a = 33'(cs);
        mul_b = signed'({1'b0, offset_length});
      end
      S_MPY: begin
        mul_a = 33'(sn);
        mul_b = signed'({1'b0, offset_length});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round to nearest, ties up
  always_comb begin
    mul_ext = {mul_p[49], mul_p};
    rate_r  = (mul_ext + RATE_HALF) >>> RATE_SH;
    pos_r   = (mul_ext + POS_HALF) >>> POS_SH;
    pt_r    = (mul_ext + PT_HALF) >>> PT_SH;
    hd_r    = (mul_ext + 51'sd1) >>> 1;
  end

  always_comb begin
    base        = (state inside {S_MDY, S_MPY}) ? x_acc : y_acc;
    step_d      = (state inside {S_MPY, S_PYF}) ? pt_r[33:0] : pos_r[33:0];
    acc_sum     = 34'(base) + step_d;
    acc_ovf     = (acc_sum[33:31] != {3{acc_sum[33]}});
    acc_clamped = acc_ovf ? (acc_sum[33] ? 32'sh80000000 : 32'sh7fffffff)
                          : acc_sum[31:0];
    head_wide   = t - PI34;
    head_new    = head_wide[31:0];
    wrap_done   = !t[33] && (t < TWO_PI34);
    cor_start   = (state == S_IDLE && cmd_valid) || (state == S_WRAP && wrap_done);
    cor_angle   = (state == S_IDLE) ? heading_acc : head_new;
  end

  upi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .trig  (cor_trig)
  );

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (rst) begin
      state          <= S_IDLE;
      pose_valid     <= 1'b0;
      time_step      <= TIME_STEP_RST;
      offset_length  <= '0;
      x_acc          <= '0;
      y_acc          <= '0;
      heading_acc    <= '0;
      last_x_rate    <= '0;
      last_y_rate    <= '0;
      last_turn_rate <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TIME_STEP:     time_step     <= cfg_data;
          CFG_OFFSET_LENGTH: offset_length <= cfg_data;
          default: ;
        endcase
      end
      if (pose_valid && pose_ready && state != S_OUT) begin
        pose_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            spd   <= cmd_data.linear_speed;
            trn   <= cmd_data.turn_rate;
            sat   <= 1'b0;
            state <= S_WAIT1;
          end
        end
        S_WAIT1: begin
          if (cor_done) begin
            cs    <= cor_trig.cos_val;
            sn    <= cor_trig.sin_val;
            state <= S_MXR;
          end
        end
        S_MXR: state <= S_MYR;
        S_MYR: begin
          xr    <= rate_r[31:0];
          state <= S_MDX;
        end
        S_MDX: begin
          yr    <= rate_r[31:0];
          state <= S_MDY;
        end
        S_MDY: begin
          x_acc <= acc_clamped;
          sat   <= sat | acc_ovf;
          state <= S_MDH;
        end
        S_MDH: begin
          y_acc <= acc_clamped;
          sat   <= sat | acc_ovf;
          state <= S_WRAP0;
        end
        S_WRAP0: begin
          t     <= 34'(heading_acc) + hd_r[33:0] + PI34;
          state <= S_WRAP;
        end
        S_WRAP: begin
          if (t[33]) begin
            t <= t + TWO_PI34;
          end else if (!wrap_done) begin
            t <= t - TWO_PI34;
          end else begin
            heading_acc    <= head_new;
            last_x_rate    <= xr;
            last_y_rate    <= yr;
            last_turn_rate <= trn;
            state          <= S_WAIT2;
          end
        end
        S_WAIT2: begin
          if (cor_done) begin
            cs    <= cor_trig.cos_val;
            sn    <= cor_trig.sin_val;
            state <= S_MPX;
          end
        end
        S_MPX: state <= S_MPY;
        S_MPY: begin
          px    <= acc_clamped;
          sat   <= sat | acc_ovf;
          state <= S_PYF;
        end
        S_PYF: begin
          py    <= acc_clamped;
          sat   <= sat | acc_ovf;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!pose_valid || pose_ready) begin
            pose_data.pos_x     <= x_acc;
            pose_data.pos_y     <= y_acc;
            pose_data.heading   <= heading_acc[30:15];
            pose_data.point_x   <= px;
            pose_data.point_y   <= py;
            pose_data.saturated <= sat;
            pose_valid          <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("request accepted while previous one in flight");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    heading_acc >= -PI_Q28 && heading_acc < PI_Q28)
    else $error("heading left [-pi,pi)");

  a_cordic_done_expected: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> (state == S_WAIT1 || state == S_WAIT2))
    else $error("cordic finished outside a wait state");

  a_pose_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(pose_valid) |-> $past(state) == S_OUT)
    else $error("pose raised without final state");
`endif

endmodule

// ===== hw/rtl/upi_cordic.sv =====
// ----------------------------------------------------------------------------
// upi_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle. Angle in Q28 within
// [-pi,pi), cos and sin out in Q30. Angles past +-pi/2 are folded by pi.
// ----------------------------------------------------------------------------
module upi_cordic
  import upi_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output upi_trig_t          trig
);

  localparam int IW = $clog2(STEPS);
  localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

  logic               busy;
  logic               neg;
  logic [IW-1:0]      iter;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [31:0] z;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [31:0] a;
  logic signed [33:0] x_next;
  logic signed [33:0] y_next;
  logic signed [31:0] z_next;
  logic signed [31:0] z_fold;
  logic               fold;

  always_comb begin
    dx = y >>> iter;
    dy = x >>> iter;
    a  = ATAN_Q28[5'(iter)];
    if (!z[31]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - a;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + a;
    end
  end

  always_comb begin
    if (angle > HALF_PI_Q28) begin
      z_fold = angle - PI_Q28;
      fold   = 1'b1;
    end else if (angle < -HALF_PI_Q28) begin
      z_fold = angle + PI_Q28;
      fold   = 1'b1;
    end else begin
      z_fold = angle;
      fold   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= 34'(GAIN_Q30);
        y    <= '0;
        z    <= z_fold;
        neg  <= fold;
        iter <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        x    <= x_next;
        y    <= y_next;
        z    <= z_next;
        iter <= iter + 1'b1;
        if (iter == LAST) begin
          busy         <= 1'b0;
          done         <= 1'b1;
          trig.cos_val <= neg ? 32'(-x_next) : 32'(x_next);
          trig.sin_val <= neg ? 32'(-y_next) : 32'(y_next);
        end
      end
    end
  end

endmodule

// ===== test/tb_unicycle_pose_integrator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unicycle_pose_integrator_top
// Self-checking bench for the unicycle pose integrator. A bit-exact software
// copy of the odometry (CORDIC split, trapezoid integration, heading wrap,
// clamping, offset point) predicts every pose from each accepted request.
// Directed corner requests come first, then random phases under several
// register settings, all but one with random idling on request and pose.
// ----------------------------------------------------------------------------
import upi_pkg::*;

localparam int     TRIG_STEPS     = 16;
localparam int     FRAC_BITS      = 16;
localparam longint ANG_PI         = 843314857;
localparam longint ANG_TWO_PI     = 2 * ANG_PI;
localparam longint ANG_HALF_PI    = 421657428;
localparam longint ANG_QUARTER_PI = 210828714;
localparam longint UNIT_GAIN      = 652032874;
localparam longint POS_HI         = 64'sd2147483647;
localparam longint POS_LO         = -64'sd2147483648;

class pose_tracker;
  longint    step;
  longint    reach;
  longint    x_pos;
  longint    y_pos;
  longint    head;
  longint    prev_vx;
  longint    prev_vy;
  longint    prev_w;
  longint    atan_tab [TRIG_STEPS];
  bit        clipped;
  upi_pose_t poses_due [$];
  int        errors;

  function new();
    longint acc;
    longint term;
    step    = 1966;
    reach   = 0;
    x_pos   = 0;
    y_pos   = 0;
    head    = 0;
    prev_vx = 0;
    prev_vy = 0;
    prev_w  = 0;
    errors  = 0;
    for (int i = 0; i < TRIG_STEPS; i++) begin
      if (i == 0) begin
        atan_tab[i] = ANG_QUARTER_PI;
      end else begin
        acc = 0;
        for (int k = 0; (2 * k + 1) * i <= 60; k++) begin
          term = (longint'(1) << (60 - (2 * k + 1) * i)) / longint'(2 * k + 1);
          acc += (k % 2 != 0) ? -term : term;
        end
        atan_tab[i] = round_off(acc, 32);
      end
    end
  endfunction

  // round to nearest, ties toward +inf
  function longint round_off(longint val, int sh);
    return (val + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function longint clamp32(longint val);
    if (val > POS_HI) begin
      clipped = 1'b1;
      return POS_HI;
    end
    if (val < POS_LO) begin
      clipped = 1'b1;
      return POS_LO;
    end
    return val;
  endfunction

  // cos/sin in Q30 of a Q28 angle in [-pi,pi)
  function void rotate(input longint angle, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     flip;
    x    = UNIT_GAIN;
    y    = 0;
    z    = angle;
    flip = 1'b0;
    if (z > ANG_HALF_PI) begin
      z -= ANG_PI;
      flip = 1'b1;
    end else if (z < -ANG_HALF_PI) begin
      z += ANG_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < TRIG_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_tab[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      CFG_TIME_STEP:     step  = longint'(val);
      CFG_OFFSET_LENGTH: reach = longint'(val);
      default: ;
    endcase
  endfunction

  function void take_command(upi_cmd_t cmd);
    longint    spd;
    longint    rate;
    longint    c;
    longint    s;
    longint    vx;
    longint    vy;
    longint    turn;
    longint    px;
    longint    py;
    upi_pose_t want;
    spd     = longint'(cmd.linear_speed);
    rate    = longint'(cmd.turn_rate);
    clipped = 1'b0;
    rotate(head, c, s);
    vx    = round_off(spd * c, 18);
    vy    = round_off(spd * s, 18);
    x_pos = clamp32(x_pos + round_off((vx + prev_vx) * step, 41 - FRAC_BITS));
    y_pos = clamp32(y_pos + round_off((vy + prev_vy) * step, 41 - FRAC_BITS));
    turn  = head + round_off((rate + prev_w) * step, 1) + ANG_PI;
    turn  = turn % ANG_TWO_PI;
    if (turn < 0) turn += ANG_TWO_PI;
    head    = turn - ANG_PI;
    prev_vx = vx;
    prev_vy = vy;
    prev_w  = rate;
    rotate(head, c, s);
    px = clamp32(x_pos + round_off(reach * c, 42 - FRAC_BITS));
    py = clamp32(y_pos + round_off(reach * s, 42 - FRAC_BITS));
    want.pos_x     = x_pos[31:0];
    want.pos_y     = y_pos[31:0];
    want.heading   = head[30:15];
    want.point_x   = px[31:0];
    want.point_y   = py[31:0];
    want.saturated = clipped;
    poses_due.push_back(want);
  endfunction

  function void compare(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_pose(upi_pose_t got);
    upi_pose_t want;
    if (poses_due.size() == 0) begin
      $error("pose with no request outstanding");
      errors++;
      return;
    end
    want = poses_due.pop_front();
    compare("pos_x", want.pos_x, got.pos_x);
    compare("pos_y", want.pos_y, got.pos_y);
    compare("heading", 32'(want.heading), 32'(got.heading));
    compare("point_x", want.point_x, got.point_x);
    compare("point_y", want.point_y, got.point_y);
    compare("saturated", {31'd0, want.saturated}, {31'd0, got.saturated});
  endfunction
endclass

module tb_unicycle_pose_integrator_top;

  localparam int                 LATENCY_PAD    = 64;
  localparam int                 WATCHDOG_LIMIT = 4000;
  localparam int                 PHASE_ITEMS    = 330;
  localparam logic signed [15:0] Q_MAX          = 16'sh7fff;
  localparam logic signed [15:0] Q_MIN          = 16'sh8000;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 cmd_valid  = 1'b0;
  logic                 cmd_ready;
  upi_cmd_t             cmd_data   = '0;
  logic                 pose_valid;
  logic                 pose_ready = 1'b0;
  upi_pose_t            pose_data;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [15:0]          cfg_data   = '0;

  pose_tracker board;
  bit          steady      = 1'b0;
  int          stall_left  = 0;
  int          idle_cycles = 0;

  unicycle_pose_integrator_top dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_data   (cmd_data),
    .pose_valid (pose_valid),
    .pose_ready (pose_ready),
    .pose_data  (pose_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    if (roll < 98) return $urandom_range(5, 30);
    return $urandom_range(60, 200);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      pose_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pose_ready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && pose_valid && pose_ready) board.check_pose(pose_data);
  end

  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (pose_valid && pose_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_cmd(input logic signed [15:0] spd, input logic signed [15:0] rate);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= '{linear_speed: spd, turn_rate: rate};
    do @(posedge clk); while (!(cmd_valid && cmd_ready));
    board.take_command(cmd_data);
  endtask

  // stop requests, let every pose come back, then let the sequencer settle
  task automatic drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (board.poses_due.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] ts, input logic [15:0] off);
    drain();
    write_reg(CFG_TIME_STEP, ts);
    write_reg(CFG_OFFSET_LENGTH, off);
    write_reg(CFG_IDX_W'($urandom_range(2, 255)), 16'($urandom));
  endtask

  function automatic logic signed [15:0] extreme();
    case ($urandom_range(0, 4))
      0:       return Q_MIN;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return Q_MAX;
    endcase
  endfunction

  task automatic random_items(input int count);
    logic signed [15:0] spd;
    logic signed [15:0] rate;
    int                 roll;
    spd  = 16'sd0;
    rate = 16'sd0;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        spd  = 16'($urandom);
        rate = 16'($urandom);
      end else if (roll < 65) begin
        spd  = 16'(int'($urandom_range(0, 600)) - 300);
        rate = 16'(int'($urandom_range(0, 600)) - 300);
      end else if (roll < 80) begin
        spd  = extreme();
        rate = extreme();
      end else begin
        spd  = spd + 16'(int'($urandom_range(0, 64)) - 32);
        rate = rate + 16'(int'($urandom_range(0, 64)) - 32);
      end
      send_cmd(spd, rate);
    end
  endtask

  task automatic run_phase(input logic [15:0] ts, input logic [15:0] off, input bit calm);
    set_regs(ts, off);
    steady = calm;
    random_items(PHASE_ITEMS);
    steady = 1'b0;
  endtask

  initial begin
    board = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset register values
    send_cmd(16'sd0, 16'sd0);
    send_cmd(Q_MAX, 16'sd0);
    send_cmd(Q_MIN, 16'sd0);
    send_cmd(16'sd0, Q_MAX);
    send_cmd(16'sd0, Q_MIN);
    send_cmd(Q_MAX, Q_MAX);
    send_cmd(Q_MIN, Q_MIN);
    send_cmd(-16'sd1, 16'sd1);

    // longest step and offset: multi-turn heading wrap
    set_regs(16'hffff, 16'hffff);
    send_cmd(16'sd0, Q_MAX);
    send_cmd(16'sd0, Q_MAX);
    send_cmd(Q_MIN, Q_MIN);
    send_cmd(Q_MAX, Q_MIN);
    send_cmd(16'sd0, 16'sd0);

    // zero step: pose holds, rates still latch
    set_regs(16'h0000, 16'h8000);
    send_cmd(16'sd12345, 16'sd777);
    send_cmd(Q_MIN, Q_MAX);

    set_regs(16'h0001, 16'h0000);
    send_cmd(Q_MAX, Q_MAX);
    send_cmd(Q_MIN, Q_MIN);

    run_phase(16'($urandom_range(1, 65535)), 16'($urandom), 1'b0);
    run_phase(16'hffff, 16'hffff, 1'b0);
    run_phase(16'h0001, 16'h0000, 1'b1);
    run_phase(16'h0000, 16'($urandom), 1'b0);
    run_phase(16'($urandom), 16'($urandom), 1'b0);

    drain();
    if (board.errors == 0 && board.poses_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/upi_pkg.sv
hw/rtl/upi_cordic.sv
hw/rtl/unicycle_pose_integrator_top.sv
test/tb_unicycle_pose_integrator_top.sv
